// File: hw/rtl/epdc_pkg.sv
// Shared types, constants and helpers for the EVM push-data diff checker.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package epdc_pkg;

    localparam int BYTES_PER_ITEM = 8;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = BYTES_PER_ITEM * BYTE_W;
    localparam int NVALID_W       = 4;
    localparam int PUSH_W         = 6;
    localparam int LIMIT_W        = 10;
    localparam int COUNT_W        = 11;

    localparam logic [BYTE_W-1:0]   PUSH_FIRST  = 8'h60;
    localparam logic [BYTE_W-1:0]   PUSH_LAST   = 8'h7F;
    localparam logic [BYTE_W-1:0]   PUSH_BASE   = 8'h5F;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 10'd256;
    localparam logic [NVALID_W-1:0] FULL_ITEM   = 4'd8;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic [BYTES_PER_ITEM-1:0]             walk;   // byte takes part in the scan
        logic [BYTES_PER_ITEM-1:0]             diff;   // template and variant differ
        logic [BYTES_PER_ITEM-1:0][PUSH_W-1:0] plen;   // push-data length if opcode
        logic                                  inc;    // full item whose words differ
        logic                                  last;
    } t_entry;

    // Number of push-data bytes that follow a template byte at a boundary.
    function automatic logic [PUSH_W-1:0] push_len(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b - PUSH_BASE;
        if (b >= PUSH_FIRST && b <= PUSH_LAST) begin
            return d[PUSH_W-1:0];
        end
        return '0;
    endfunction

endpackage

// File: hw/rtl/epdc_item_if.sv
// Request channel for one pair of eight-byte code words.
// Depends on epdc_pkg for the field widths.
`timescale 1ns / 1ps

interface epdc_item_if;
    logic                                valid;
    logic                                ready;
    logic [epdc_pkg::WORD_W-1:0]         template_word;
    logic [epdc_pkg::WORD_W-1:0]         variant_word;
    logic [epdc_pkg::NVALID_W-1:0]       valid_bytes;
    logic                                last;

    modport source (output valid, output template_word, output variant_word,
                    output valid_bytes, output last, input ready);
    modport sink   (input valid, input template_word, input variant_word,
                    input valid_bytes, input last, output ready);
endinterface

// File: hw/rtl/epdc_res_if.sv
// Result channel: one request per code pair, issued on its last item.
// Depends on epdc_pkg for the field widths.
`timescale 1ns / 1ps

interface epdc_res_if;
    logic                                valid;
    logic                                ready;
    logic                                matches_res;
    logic                                boundary_conflict;
    logic [epdc_pkg::COUNT_W-1:0]        word_count;

    modport source (output valid, output matches_res, output boundary_conflict,
                    output word_count, input ready);
    modport sink   (input valid, input matches_res, input boundary_conflict,
                    input word_count, output ready);
endinterface

// File: hw/rtl/epdc_front.sv
// Front end: accepts input requests and classifies each byte of the pair.
// Depends on epdc_pkg and epdc_item_if.
`timescale 1ns / 1ps

module epdc_front (
    epdc_item_if.sink          i_item,
    input  logic               i_full,
    output logic               o_push,
    output epdc_pkg::t_entry   o_entry
);

    logic [epdc_pkg::NVALID_W-1:0] nvalid;
    logic [epdc_pkg::BYTE_W-1:0]   tb;
    logic [epdc_pkg::BYTE_W-1:0]   vb;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    // Counts above eight behave as a full item.
    assign nvalid = (i_item.valid_bytes > epdc_pkg::FULL_ITEM) ? epdc_pkg::FULL_ITEM
                                                               : i_item.valid_bytes;

    always_comb begin
        tb = '0;
        vb = '0;
        for (int k = 0; k < epdc_pkg::BYTES_PER_ITEM; k++) begin
            tb = i_item.template_word[k*epdc_pkg::BYTE_W +: epdc_pkg::BYTE_W];
            vb = i_item.variant_word[k*epdc_pkg::BYTE_W +: epdc_pkg::BYTE_W];
            o_entry.walk[k] = (epdc_pkg::NVALID_W'(k) < nvalid);
            o_entry.diff[k] = (tb != vb);
            o_entry.plen[k] = epdc_pkg::push_len(tb);
        end
        o_entry.inc  = (nvalid == epdc_pkg::FULL_ITEM) &&
                       (i_item.template_word != i_item.variant_word);
        o_entry.last = i_item.last;
    end

endmodule

// File: hw/rtl/epdc_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on epdc_pkg for the entry type.
`timescale 1ns / 1ps

module epdc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  epdc_pkg::t_entry   i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output epdc_pkg::t_entry   o_entry
);

    epdc_pkg::t_entry r_mem [2];
    logic             r_wr_ptr;
    logic             n_wr_ptr;
    logic             r_rd_ptr;
    logic             n_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

// File: hw/rtl/epdc_back.sv
// Back end: walks instruction boundaries, counts differing words, issues results.
// Depends on epdc_pkg and epdc_res_if.
`timescale 1ns / 1ps

module epdc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [epdc_pkg::LIMIT_W-1:0]      i_cfg_wdata,
    input  logic                              i_valid,
    input  epdc_pkg::t_entry                  i_entry,
    output logic                              o_pop,
    epdc_res_if.source                        o_res
);

    logic [epdc_pkg::PUSH_W-1:0]  r_push_left;
    logic [epdc_pkg::PUSH_W-1:0]  n_push_left;
    logic [epdc_pkg::COUNT_W-1:0] r_diff_count;
    logic [epdc_pkg::COUNT_W-1:0] n_diff_count;
    logic                         r_conflict;
    logic                         n_conflict;
    logic [epdc_pkg::LIMIT_W-1:0] r_limit;
    logic                         r_out_valid;
    logic                         r_out_match;
    logic                         r_out_conflict;
    logic [epdc_pkg::COUNT_W-1:0] r_out_count;
    logic [epdc_pkg::COUNT_W-1:0] limit_ext;
    logic                         match;

    assign limit_ext = epdc_pkg::COUNT_W'(r_limit);

    // A last item can only leave the queue when the result register is free.
    assign o_pop = i_valid && (!i_entry.last || !r_out_valid || o_res.ready);

    always_comb begin
        n_push_left  = r_push_left;
        n_conflict   = r_conflict;
        for (int k = 0; k < epdc_pkg::BYTES_PER_ITEM; k++) begin
            if (i_entry.walk[k]) begin
                if (n_push_left == '0) begin
                    n_conflict  = n_conflict | i_entry.diff[k];
                    n_push_left = i_entry.plen[k];
                end else begin
                    n_push_left = n_push_left - 1'b1;
                end
            end
        end
        n_diff_count = r_diff_count;
        if (i_entry.inc && (r_diff_count < limit_ext + 1'b1)) begin
            n_diff_count = r_diff_count + 1'b1;
        end
        match = !n_conflict && (n_diff_count <= limit_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_left  <= '0;
            r_diff_count <= '0;
            r_conflict   <= 1'b0;
            r_limit      <= epdc_pkg::LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_pop) begin
                if (i_entry.last) begin
                    r_push_left  <= '0;
                    r_diff_count <= '0;
                    r_conflict   <= 1'b0;
                end else begin
                    r_push_left  <= n_push_left;
                    r_diff_count <= n_diff_count;
                    r_conflict   <= n_conflict;
                end
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_out_match    <= match;
            r_out_conflict <= n_conflict;
            r_out_count    <= n_diff_count;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.matches_res       = r_out_match;
    assign o_res.boundary_conflict = r_out_conflict;
    assign o_res.word_count        = r_out_count;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |-> (!r_out_valid || o_res.ready))
        else $error("pending result overwritten");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_push_left == '0 && r_diff_count == '0 && !r_conflict))
        else $error("pair state not cleared after last item");

    a_match_implies_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_match) |-> !r_out_conflict)
        else $error("match reported together with a boundary conflict");

endmodule

// File: hw/rtl/evm_pushdata_diff_checker.sv
// A result request is registered: its last item passes the queue, then the result register.
// Throughput: one item per cycle while the queue is not full; the push-data walk is eight chained byte steps.
// A two-entry queue and a registered result let input and output stall apart.
// Reset (synchronous, active low) empties the queue, clears the pair state and
// the pending result, and sets the word limit to 256.
`timescale 1ns / 1ps

module evm_pushdata_diff_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [epdc_pkg::LIMIT_W-1:0] i_cfg_wdata,
    epdc_item_if.sink                    i_item,
    epdc_res_if.source                   o_res
);

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    epdc_pkg::t_entry front_entry;
    epdc_pkg::t_entry q_entry;

    epdc_front u_front (
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    epdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    epdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

// File: tb/sv/epdc_pair_checker.sv
// Scoreboard for the EVM push-data diff checker: watches the configuration port and both
// request channels, predicts one verdict per code pair and compares it with the block.
// Depends on epdc_pkg, epdc_item_if and epdc_res_if.
`timescale 1ns / 1ps

module epdc_pair_checker
    import epdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    epdc_item_if               i_item,
    epdc_res_if                i_res,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               match_ok;
        logic               conflict;
        logic [COUNT_W-1:0] words;
    } verdict_t;

    verdict_t           verdict_q[$];
    logic [LIMIT_W-1:0] word_limit;
    logic [PUSH_W-1:0]  skip_left;
    logic [COUNT_W-1:0] diff_tally;
    logic               conflict_acc;
    int                 fails = 0;

    task automatic flag(input string what, input verdict_t want, input verdict_t got);
        fails++;
        if (fails <= 10) begin
            $display("%0t %s: expected match=%0b conflict=%0b words=%0d,",
                     $time, what, want.match_ok, want.conflict, want.words,
                     " got match=%0b conflict=%0b words=%0d",
                     got.match_ok, got.conflict, got.words);
        end
    endtask

    // Walks the template instruction boundaries across the valid bytes of one request
    // and closes the pair on its last request.
    task automatic walk_request(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] vw,
                                input logic [NVALID_W-1:0] nb, input logic is_last);
        int                n;
        logic [BYTE_W-1:0] tb;
        logic [BYTE_W-1:0] span;
        verdict_t          v;
        n = (nb > FULL_ITEM) ? BYTES_PER_ITEM : int'(nb);
        for (int k = 0; k < n; k++) begin
            tb = tw[BYTE_W*k +: BYTE_W];
            if (skip_left == '0) begin
                if (tb != vw[BYTE_W*k +: BYTE_W]) begin
                    conflict_acc = 1'b1;
                end
                if (tb >= PUSH_FIRST && tb <= PUSH_LAST) begin
                    span      = tb - PUSH_BASE;
                    skip_left = span[PUSH_W-1:0];
                end
            end else begin
                skip_left = skip_left - 1'b1;
            end
        end
        // The count stops at limit plus one, and a larger value left by a lowered
        // limit is held as it is.
        if (n == BYTES_PER_ITEM && tw != vw && int'(diff_tally) <= int'(word_limit)) begin
            diff_tally = diff_tally + 1'b1;
        end
        if (is_last) begin
            v.match_ok = !conflict_acc && (int'(diff_tally) <= int'(word_limit));
            v.conflict = conflict_acc;
            v.words    = diff_tally;
            verdict_q.insert(verdict_q.size(), v);
            skip_left    = '0;
            diff_tally   = '0;
            conflict_acc = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (!i_rst_n) begin
            verdict_q.delete();
            word_limit   = LIMIT_RESET;
            skip_left    = '0;
            diff_tally   = '0;
            conflict_acc = 1'b0;
        end else begin
            if (i_cfg_we) begin
                word_limit = i_cfg_wdata;
            end
            if (i_res.valid && i_res.ready) begin
                got.match_ok = i_res.matches_res;
                got.conflict = i_res.boundary_conflict;
                got.words    = i_res.word_count;
                if (verdict_q.size() == 0) begin
                    flag("unexpected result", '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        flag("result mismatch", want, got);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                walk_request(i_item.template_word, i_item.variant_word,
                             i_item.valid_bytes, i_item.last);
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb_evm_pushdata_diff_checker.sv
// Top of the EVM push-data diff checker testbench: clock, reset, limit writes, code-pair
// stimulus with random idling on both channels, and the final verdict.
// Depends on epdc_pkg, both channel interfaces, the block and epdc_pair_checker.
`timescale 1ns / 1ps

module tb_evm_pushdata_diff_checker;
    import epdc_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [BYTE_W-1:0] OP_STOP     = 8'h00;
    localparam logic [BYTE_W-1:0] OP_JUMPDEST = 8'h5B;
    localparam logic [BYTE_W-1:0] OP_DUP1     = 8'h80;

    typedef enum int {SHAPE_SAME, SHAPE_DATA, SHAPE_STRAY, SHAPE_NOISE} shape_e;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending;
    int                 items_sent = 0;
    bit                 tx_quiet = 1'b0;
    bit                 rx_hold = 1'b0;

    epdc_item_if item_ch ();
    epdc_res_if  res_ch ();

    always #6 clk = ~clk;

    evm_pushdata_diff_checker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_res       (res_ch)
    );

    epdc_pair_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_item       (item_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Valid stays high from one request to the next unless a gap is drawn.
    task automatic send_item(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] vw,
                             input logic [NVALID_W-1:0] nb, input logic is_last);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.template_word <= tw;
        item_ch.variant_word  <= vw;
        item_ch.valid_bytes   <= nb;
        item_ch.last          <= is_last;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Builds a template, derives the variant according to the shape and streams both.
    task automatic send_pair(input int len, input shape_e shape);
        logic [BYTE_W-1:0]   tpl[$];
        logic [BYTE_W-1:0]   var_b[$];
        bit                  in_data[$];
        logic [BYTE_W-1:0]   b;
        logic [WORD_W-1:0]   tw;
        logic [WORD_W-1:0]   vw;
        logic [NVALID_W-1:0] nb;
        int                  left;
        int                  r;
        int                  n;
        left = 0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                b = BYTE_W'($urandom_range(int'(PUSH_FIRST), int'(PUSH_FIRST) + 3));
            end else if (r == 2) begin
                b = BYTE_W'($urandom_range(int'(PUSH_FIRST), int'(PUSH_LAST)));
            end else begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            tpl.insert(tpl.size(), b);
            in_data.insert(in_data.size(), left != 0);
            if (left != 0) begin
                left--;
            end else if (b >= PUSH_FIRST && b <= PUSH_LAST) begin
                left = int'(b - PUSH_BASE);
            end
        end
        for (int i = 0; i < len; i++) begin
            b = tpl[i];
            if (shape == SHAPE_NOISE) begin
                b = BYTE_W'($urandom_range(0, 255));
            end else if (shape != SHAPE_SAME && in_data[i] && $urandom_range(0, 3) == 0) begin
                b = b ^ BYTE_W'($urandom_range(1, 255));
            end
            var_b.insert(var_b.size(), b);
        end
        if (shape == SHAPE_STRAY) begin
            r = $urandom_range(0, len - 1);
            var_b[r] = var_b[r] ^ BYTE_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < len; i += BYTES_PER_ITEM) begin
            n  = (len - i < BYTES_PER_ITEM) ? len - i : BYTES_PER_ITEM;
            tw = rand_word();
            vw = rand_word();
            for (int k = 0; k < n; k++) begin
                tw[BYTE_W*k +: BYTE_W] = tpl[i + k];
                vw[BYTE_W*k +: BYTE_W] = var_b[i + k];
            end
            nb = NVALID_W'(n);
            if (n == BYTES_PER_ITEM && $urandom_range(0, 24) == 0) begin
                nb = NVALID_W'($urandom_range(9, 15));
            end
            // Stray short or empty requests break the byte stream now and then.
            if ($urandom_range(0, 39) == 0) begin
                send_item(rand_word(), rand_word(), NVALID_W'($urandom_range(0, 7)),
                          $urandom_range(0, 3) == 0);
            end
            send_item(tw, vw, nb, i + BYTES_PER_ITEM >= len);
        end
    endtask

    function automatic logic [LIMIT_W-1:0] phase_limit(input int p);
        case (p)
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return LIMIT_W'(1);
            end
            3: begin
                return LIMIT_W'(3);
            end
            4: begin
                return LIMIT_W'($urandom_range(0, 1023));
            end
            5: begin
                return LIMIT_RESET;
            end
            default: begin
                return LIMIT_W'(2);
            end
        endcase
    endfunction

    initial begin : result_sink
        int n;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rx_hold) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                n = pick_gap(1'b0);
                if (n > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        #8000000;
        $display("evm_pushdata_diff_checker regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] tw;
        logic [WORD_W-1:0] vw;
        int                base_items;
        int                r;
        int                len;
        bit                paused;
        shape_e            shape;
        paused                = 1'b0;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.template_word <= '0;
        item_ch.variant_word  <= '0;
        item_ch.valid_bytes   <= '0;
        item_ch.last          <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identical code at both ends of the byte range, under the reset limit.
        send_item('0, '0, FULL_ITEM, 1'b1);
        send_item('1, '1, FULL_ITEM, 1'b1);

        // PUSH32 at offset 0 covers offsets 1..32; offset 33 starts an instruction.
        send_item({{7{8'h11}}, PUSH_LAST}, {{7{8'hEE}}, PUSH_LAST}, FULL_ITEM, 1'b0);
        repeat (3) begin
            w = rand_word();
            send_item(w, ~w, FULL_ITEM, 1'b0);
        end
        send_item({{6{OP_JUMPDEST}}, OP_JUMPDEST, 8'h42}, {{6{OP_JUMPDEST}}, OP_STOP, 8'h99},
                  FULL_ITEM, 1'b1);

        // PUSH0 and DUP1 are single bytes around the push range; PUSH1 guards one byte.
        tw = {8'h33, 8'h22, 8'h11, PUSH_LAST, OP_DUP1, 8'hAA, PUSH_FIRST, PUSH_BASE};
        vw = {8'hCC, 8'hDD, 8'hEE, PUSH_LAST, OP_DUP1, 8'h55, PUSH_FIRST, PUSH_BASE};
        send_item(tw, vw, FULL_ITEM, 1'b0);
        send_item(rand_word(), rand_word(), NVALID_W'(3), 1'b1);

        // A short request inside a pair is walked but never counted; an empty last
        // request still closes the pair.
        w = rand_word();
        send_item(w, w ^ 64'hFFFF_FF00_0000_0000, NVALID_W'(5), 1'b0);
        send_item(rand_word(), rand_word(), NVALID_W'(0), 1'b1);

        // Byte counts above eight behave like a full request.
        tw = {OP_STOP, PUSH_FIRST, {6{OP_JUMPDEST}}};
        send_item(tw, {8'hFF, PUSH_FIRST, {6{OP_JUMPDEST}}}, NVALID_W'(15), 1'b1);
        send_item(tw, tw, NVALID_W'(9), 1'b1);

        // Saturate the count under a limit of five, then lower the limit mid-pair so
        // the count sits above the new ceiling and must hold.
        write_limit(LIMIT_W'(5));
        repeat (7) begin
            w = rand_word();
            send_item(w, w ^ 64'h1, FULL_ITEM, 1'b0);
        end
        write_limit(LIMIT_W'(2));
        w = rand_word();
        send_item(w, ~w, FULL_ITEM, 1'b1);

        for (int p = 0; p < 7; p++) begin
            write_limit(phase_limit(p));
            tx_quiet = (p == 1 || p == 3);
            if (p == 1) begin
                // One long pair of differing words under the widest limit.
                for (int i = 0; i < 40; i++) begin
                    w = rand_word();
                    send_item(w, ~w, FULL_ITEM, i == 39);
                end
                tx_quiet = 1'b0;
            end
            if (p == 2) begin
                rx_hold = 1'b1;
            end
            base_items = items_sent;
            while (items_sent - base_items < 70) begin
                if (p == 5 && !paused && items_sent - base_items >= 35) begin
                    drain();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (p == 2) begin
                    len = $urandom_range(1, 8);
                end else if (r < 70) begin
                    len = $urandom_range(1, 24);
                end else if (r < 95) begin
                    len = $urandom_range(25, 64);
                end else begin
                    len = $urandom_range(65, 160);
                end
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    shape = SHAPE_SAME;
                end else if (r < 70) begin
                    shape = SHAPE_DATA;
                end else if (r < 85) begin
                    shape = SHAPE_STRAY;
                end else begin
                    shape = SHAPE_NOISE;
                end
                send_pair(len, shape);
            end
        end
        tx_quiet = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("evm_pushdata_diff_checker regression: pass");
        end else begin
            $display("evm_pushdata_diff_checker regression: fail");
        end
        $finish;
    end

endmodule
